FILE: src/rgm5_pkg.sv
// rgm5_pkg: constants, types and register map of the range gated median filter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rgm5_pkg;

    localparam int WINDOW   = 5;
    localparam int SAMPLE_W = 15;
    localparam int DATA_W   = 16;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int MID_RANK = (WINDOW - 1) / 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [0:0] REG_MAX_RANGE = 1'b0;

    localparam logic [SAMPLE_W-1:0] MAX_RANGE_RESET = SAMPLE_W'(400);
    localparam logic [DATA_W-1:0]   OUT_OF_RANGE    = {DATA_W{1'b1}};

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef sample_t [WINDOW-1:0] sample_vec_t;
    typedef logic [IDX_W-1:0] cell_idx_t;

endpackage

FILE: src/rgm5_cell.sv
// rgm5_cell: one window cell; stores a sample, shifts it on, and finds its own rank
// depends on rgm5_pkg
`timescale 1ns / 1ps

module rgm5_cell
    import rgm5_pkg::*;
(
    input  logic        clk,
    input  logic        shift_en,
    input  sample_t     shift_in,
    input  cell_idx_t   cell_idx,
    input  sample_vec_t samples,
    output sample_t     sample,
    output logic        is_median
);

    sample_t   sample_reg;
    cell_idx_t rank;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= shift_in;
        end
    end

    assign sample = sample_reg;

    // ties broken by cell position so ranks form a permutation
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if ((samples[j] < sample_reg) ||
                ((samples[j] == sample_reg) && (cell_idx_t'(j) < cell_idx)))
            begin
                rank = rank + cell_idx_t'(1);
            end
        end
    end

    assign is_median = (rank == cell_idx_t'(MID_RANK));

endmodule

FILE: src/range_gated_median5_filter_unit.sv
// range_gated_median5_filter_unit: gates raw distances, keeps the last five
// in-range samples in a chain of cells and outputs their median once filled
// depends on rgm5_pkg and rgm5_cell
`timescale 1ns / 1ps

// an accepted word is registered in the p1 stage, then in an output register that
// parts the two sides; one word per cycle while the output does not stall, limited
// by the cell update and the rank compares; a stalled output blocks the cells
// reset: asynchronous, active low; max_range_cm returns to 400, fill count and
// valid flags clear; cell contents are not reset and are written before use

module range_gated_median5_filter_unit
    import rgm5_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // [15:0] raw_distance_cm
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // [15:0] filtered_distance_cm
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    sample_t            max_range_reg;
    logic [CNT_W-1:0]   fill_cnt_reg;
    logic [CNT_W-1:0]   fill_cnt_next;
    logic               p1_valid_reg;
    logic               p1_full_reg;
    logic [DATA_W-1:0]  p1_value_reg;
    logic               m_tvalid_reg;
    logic [DATA_W-1:0]  m_tdata_reg;

    logic               cfg_wr;
    logic               s_acc;
    logic               p1_advance;
    logic               in_range;
    logic               full_next;
    sample_vec_t        samples;
    sample_vec_t        shift_src;
    logic [WINDOW-1:0]  median_hit;
    sample_t            median;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MAX_RANGE) ?
                    APB_DATA_W'(max_range_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= MAX_RANGE_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_MAX_RANGE))
        begin
            max_range_reg <= pwdata[SAMPLE_W-1:0];
        end
    end

    // gate and handshake
    assign p1_advance = !m_tvalid_reg || m_tready;
    assign s_tready   = !p1_valid_reg || p1_advance;
    assign s_acc      = s_tvalid && s_tready;
    assign in_range   = !s_tdata[DATA_W-1] && (s_tdata[SAMPLE_W-1:0] <= max_range_reg);

    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        if (s_acc && in_range && (fill_cnt_reg != CNT_W'(WINDOW)))
        begin
            fill_cnt_next = fill_cnt_reg + CNT_W'(1);
        end
    end

    assign full_next = (fill_cnt_next == CNT_W'(WINDOW));

    // chain of cells
    assign shift_src[0] = s_tdata[SAMPLE_W-1:0];

    generate
        for (genvar g = 1; g < WINDOW; g++)
        begin : g_link
            assign shift_src[g] = samples[g-1];
        end

        for (genvar g = 0; g < WINDOW; g++)
        begin : g_cell
            rgm5_cell u_cell
            (
                .clk       (clk),
                .shift_en  (s_acc && in_range),
                .shift_in  (shift_src[g]),
                .cell_idx  (cell_idx_t'(g)),
                .samples   (samples),
                .sample    (samples[g]),
                .is_median (median_hit[g])
            );
        end
    endgenerate

    always_comb
    begin
        median = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            median = median | (samples[k] & {SAMPLE_W{median_hit[k]}});
        end
    end

    // pipeline and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            p1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            p1_full_reg  <= 1'b0;
            p1_value_reg <= '0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            fill_cnt_reg <= fill_cnt_next;
            if (s_acc)
            begin
                p1_valid_reg <= 1'b1;
                p1_full_reg  <= full_next;
                p1_value_reg <= in_range ? s_tdata : OUT_OF_RANGE;
            end
            else if (p1_advance)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_advance)
            begin
                m_tvalid_reg <= p1_valid_reg;
                m_tdata_reg  <= p1_full_reg ? DATA_W'(median) : p1_value_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_cnt_reg == CNT_W'(WINDOW)) |=> (fill_cnt_reg == CNT_W'(WINDOW)))
        else $error("window full flag dropped");

    a_stall_holds_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && !p1_advance) |-> !s_tready)
        else $error("cells may change under a pending word");

    a_median_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && p1_full_reg) |-> $onehot(median_hit))
        else $error("median select not one-hot");

endmodule
